>>> src/windowed_counter_statistics_unit_assert.svh
// ----------------------------------------------------------------------------
// Windowed counter statistics - assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_COUNTER_STATISTICS_UNIT_ASSERT_SVH
`define WINDOWED_COUNTER_STATISTICS_UNIT_ASSERT_SVH

// same-cycle implication
`define WCS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wcs assertion failed");

// next-cycle implication
`define WCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wcs assertion failed");

`endif

>>> src/wcs_pkg.sv
// ----------------------------------------------------------------------------
// Windowed counter statistics - package
// Widths, codes, entry layout and the saturating helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wcs_pkg;

	localparam int MAX_SAMPLES_DEF = 64;
	localparam int CFG_W           = 48;
	localparam int CFG_IDX_W       = 4;
	localparam int MS_PER_S        = 1000;
	localparam logic [63:0] RATE_SCALE = 64'd65536000;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TYPE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECS  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POST_OP      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POST_OPERAND = 4'd3;

	localparam logic [1:0] TYPE_DELTA    = 2'd0;
	localparam logic [1:0] TYPE_PER_SEC  = 2'd1;
	localparam logic [1:0] TYPE_UNSIGNED = 2'd2;
	localparam logic [1:0] TYPE_SIGNED32 = 2'd3;

	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;

	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [47:0] arrival;
		logic [47:0] packet;
		logic [63:0] raw;
		logic [63:0] calc;
		logic        responded;
		logic        valid;
	} entry_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic         start;
		logic [127:0] dividend;
		logic [63:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quot;
		logic        over;
	} div_rsp_t;

	function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] mag,
		input logic over);
		logic [63:0] r;
		if (neg) begin
			r = (over || mag[63]) ? S64_MIN : (64'd0 - mag);
		end else begin
			r = (over || mag[63]) ? S64_MAX : mag;
		end
		return r;
	endfunction

	function automatic logic [63:0] sat_unsigned(input logic [63:0] u);
		return (u[63:47] != 17'd0) ? S64_MAX : {u[47:0], 16'd0};
	endfunction

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63]) begin
			r = a[63] ? S64_MIN : S64_MAX;
		end
		return r;
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

endpackage

>>> src/windowed_counter_statistics_unit.sv
// ----------------------------------------------------------------------------
// Windowed counter statistics unit - top level
// Sliding time window of poll samples with last, average, max and min.
//
//   beat      | handshake            | payload
//   ----------+----------------------+-----------------------------------------
//   input     | in_valid / in_ready  | kind, sample_value, now_ms, packet_time_ms
//   result    | out_valid / out_ready| last_value, average_value, max_value,
//             |                      | min_value, is_valid
//   config    | cfg_we               | cfg_index, cfg_data
//
// One beat runs an expiry pass over the oldest entries and a statistics pass
// over all kept entries, plus up to 3 divides (per-second divide, post divide,
// average divide) on the shared 128/64 divider at one bit per cycle.
// in_ready is high only when the sequencer is idle. Reset clears control
// state only; the sample store needs no clearing. A stalled result holds in
// the output register while the next beat is already being worked on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module windowed_counter_statistics_unit #(
	parameter int MAX_SAMPLES = wcs_pkg::MAX_SAMPLES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [wcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wcs_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           kind,
	input  logic [63:0]                    sample_value,
	input  logic [47:0]                    now_ms,
	input  logic [47:0]                    packet_time_ms,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [63:0]                    last_value,
	output logic [63:0]                    average_value,
	output logic [63:0]                    max_value,
	output logic [63:0]                    min_value,
	output logic                           is_valid
);
	import wcs_pkg::*;

	localparam int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int OW = IW + 2;
	localparam int EW = $bits(entry_t);

	typedef enum logic [14:0] {
		ST_IDLE     = 15'b000000000000001,
		ST_EXP_RD   = 15'b000000000000010,
		ST_EXP_CHK  = 15'b000000000000100,
		ST_NEW_RD   = 15'b000000000001000,
		ST_CALC     = 15'b000000000010000,
		ST_RATE_MUL = 15'b000000000100000,
		ST_RATE_DIV = 15'b000000001000000,
		ST_POST     = 15'b000000010000000,
		ST_POST_MUL = 15'b000000100000000,
		ST_POST_DIV = 15'b000001000000000,
		ST_STORE    = 15'b000010000000000,
		ST_ST_INIT  = 15'b000100000000000,
		ST_ST_RD    = 15'b001000000000000,
		ST_ST_ACC   = 15'b010000000000000,
		ST_DONE     = 15'b100000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [1:0]  sample_type_q;
	logic [15:0] window_seconds_q;
	logic [2:0]  post_op_q;
	logic [47:0] post_operand_q;

	// item registers
	logic        kind_q;
	logic [63:0] raw_q;
	logic [47:0] now_q, pt_q, start_q;
	logic [63:0] calc_q;
	logic [47:0] el_q;
	logic        valid_q, pneg_q;

	// window bookkeeping
	logic [IW-1:0] newest_q, idx_q;
	logic [CW-1:0] cnt_q, k_q, n_q;

	// statistics
	logic [127:0] sum_q;
	logic [63:0]  mx_q, mn_q;
	logic         avg_neg_q;
	logic [63:0]  held_last_q, held_avg_q, held_max_q, held_min_q;
	logic         held_valid_q;

	// result register
	logic        out_valid_q;
	logic [63:0] out_last_q, out_avg_q, out_max_q, out_min_q;
	logic        out_isv_q;

	mul_req_t     mul_req;
	mul_rsp_t     mul_rsp;
	div_req_t     div_req;
	div_rsp_t     div_rsp;
	logic         mul_start_q, div_start_q;
	logic [63:0]  mul_a_q, mul_b_q, div_den_q;
	logic [127:0] div_num_q;

	logic          ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, rd;
	logic [EW-1:0] ram_rdata;

	logic [OW-1:0] old_sum;
	logic [IW-1:0] oldest, nidx;
	logic [25:0]   span;
	logic [63:0]   opb, ma, mb, sv, delta;
	logic [47:0]   el;
	logic          rate_go, avg_go, out_load;
	logic          div_busy_q;

	function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
		return (i == IW'(MAX_SAMPLES - 1)) ? '0 : (i + IW'(1));
	endfunction

	always_comb begin
		old_sum = OW'(newest_q) + OW'(MAX_SAMPLES) + OW'(1) - OW'(cnt_q);
		if (old_sum >= OW'(MAX_SAMPLES)) begin
			old_sum = old_sum - OW'(MAX_SAMPLES);
		end
		oldest = old_sum[IW-1:0];
	end

	assign nidx  = next_idx(newest_q);
	assign span  = 26'(window_seconds_q) * 26'(MS_PER_S);
	assign rd    = entry_t'(ram_rdata);
	assign delta = raw_q - rd.raw;
	assign el    = pt_q - rd.packet;
	assign opb   = {{16{post_operand_q[47]}}, post_operand_q};
	assign ma    = mag64(calc_q);
	assign mb    = mag64(opb);
	assign sv    = {{32{raw_q[31]}}, raw_q[31:0]};

	assign rate_go  = !kind_q && sample_type_q == TYPE_PER_SEC && cnt_q != '0 &&
		rd.responded && delta != 64'd0 && el != 48'd0;
	assign avg_go   = (state_q == ST_ST_RD) && (k_q == cnt_q) && (n_q != '0);
	assign out_load = (!out_valid_q || out_ready) && !div_busy_q;

	assign mul_req.start    = mul_start_q;
	assign mul_req.a        = mul_a_q;
	assign mul_req.b        = mul_b_q;
	assign div_req.start    = div_start_q;
	assign div_req.dividend = div_num_q;
	assign div_req.divisor  = div_den_q;

	// store ports
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = newest_q;
		case (state_q)
			ST_EXP_RD: begin
				ram_re    = (cnt_q != '0);
				ram_raddr = oldest;
			end
			ST_NEW_RD: begin
				ram_re    = 1'b1;
				ram_raddr = newest_q;
			end
			ST_ST_RD: begin
				ram_re    = (k_q != cnt_q);
				ram_raddr = idx_q;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	assign ram_we    = (state_q == ST_STORE);
	assign ram_waddr = nidx;
	always_comb begin
		ram_wdata.arrival   = now_q;
		ram_wdata.packet    = pt_q;
		ram_wdata.raw       = kind_q ? 64'd0 : raw_q;
		ram_wdata.calc      = calc_q;
		ram_wdata.responded = !kind_q;
		ram_wdata.valid     = valid_q;
	end

	wcs_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_SAMPLES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	wcs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	wcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_type_q    <= TYPE_SIGNED32;
			window_seconds_q <= 16'd60;
			post_op_q        <= OP_NONE;
			post_operand_q   <= 48'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_TYPE:  sample_type_q    <= cfg_data[1:0];
				REG_WINDOW_SECS:  window_seconds_q <= cfg_data[15:0];
				REG_POST_OP:      post_op_q        <= cfg_data[2:0];
				REG_POST_OPERAND: post_operand_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	// unit start pulses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			mul_start_q <= (state_q == ST_CALC && rate_go) ||
				(state_q == ST_POST && post_op_q == OP_MUL);
			div_start_q <= (state_q == ST_RATE_MUL && mul_rsp.done) ||
				(state_q == ST_POST && post_op_q == OP_DIV && mb != 64'd0) || avg_go;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			newest_q     <= '0;
			cnt_q        <= '0;
			held_last_q  <= 64'd0;
			held_avg_q   <= 64'd0;
			held_max_q   <= 64'd0;
			held_min_q   <= 64'd0;
			held_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXP_RD;
					end
				end
				ST_EXP_RD: begin
					state_q <= (cnt_q != '0) ? ST_EXP_CHK : ST_NEW_RD;
				end
				ST_EXP_CHK: begin
					if (rd.arrival < start_q) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= ST_EXP_RD;
					end else begin
						state_q <= ST_NEW_RD;
					end
				end
				ST_NEW_RD: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (kind_q) begin
						state_q <= ST_STORE;
					end else if (rate_go) begin
						state_q <= ST_RATE_MUL;
					end else begin
						state_q <= ST_POST;
					end
				end
				ST_RATE_MUL: begin
					if (mul_rsp.done) begin
						state_q <= ST_RATE_DIV;
					end
				end
				ST_RATE_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (post_op_q == OP_MUL) begin
						state_q <= ST_POST_MUL;
					end else if (post_op_q == OP_DIV && mb != 64'd0) begin
						state_q <= ST_POST_DIV;
					end else begin
						state_q <= ST_STORE;
					end
				end
				ST_POST_MUL: begin
					if (mul_rsp.done) begin
						state_q <= ST_STORE;
					end
				end
				ST_POST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					newest_q     <= nidx;
					held_valid_q <= valid_q;
					if (cnt_q != CW'(MAX_SAMPLES)) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (!kind_q) begin
						held_last_q <= calc_q;
						state_q     <= ST_ST_INIT;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_ST_INIT: begin
					state_q <= ST_ST_RD;
				end
				ST_ST_RD: begin
					if (k_q != cnt_q) begin
						state_q <= ST_ST_ACC;
					end else if (n_q != '0) begin
						state_q    <= ST_DONE;
						held_max_q <= mx_q;
						held_min_q <= mn_q;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_ST_ACC: begin
					state_q <= ST_ST_RD;
				end
				ST_DONE: begin
					// average divide, if one was started, must land first
					if (out_load) begin
						state_q <= ST_IDLE;
					end
					if (div_rsp.done) begin
						held_avg_q <= from_mag(avg_neg_q, div_rsp.quot, div_rsp.over);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// average divide in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
		end else if (avg_go) begin
			div_busy_q <= 1'b1;
		end else if (div_rsp.done) begin
			div_busy_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					kind_q  <= kind;
					raw_q   <= sample_value;
					now_q   <= now_ms;
					pt_q    <= packet_time_ms;
					start_q <= (now_ms >= 48'(span)) ? (now_ms - 48'(span)) : 48'd0;
				end
			end
			ST_CALC: begin
				el_q    <= el;
				mul_a_q <= delta;
				mul_b_q <= RATE_SCALE;
				if (kind_q) begin
					valid_q <= 1'b0;
					calc_q  <= 64'd0;
				end else if (sample_type_q == TYPE_SIGNED32) begin
					calc_q  <= {sv[47:0], 16'd0};
					valid_q <= 1'b1;
				end else if (sample_type_q == TYPE_UNSIGNED) begin
					calc_q  <= sat_unsigned(raw_q);
					valid_q <= 1'b1;
				end else if (cnt_q != '0 && rd.responded) begin
					valid_q <= 1'b1;
					if (sample_type_q == TYPE_PER_SEC && delta != 64'd0) begin
						calc_q <= S64_MAX;
					end else begin
						calc_q <= sat_unsigned(delta);
					end
				end else begin
					valid_q <= 1'b0;
					calc_q  <= sat_unsigned(raw_q);
				end
			end
			ST_RATE_MUL: begin
				div_num_q <= mul_rsp.prod;
				div_den_q <= {16'd0, el_q};
			end
			ST_RATE_DIV: begin
				if (div_rsp.done) begin
					calc_q <= from_mag(1'b0, div_rsp.quot, div_rsp.over);
				end
			end
			ST_POST: begin
				pneg_q    <= (calc_q[63] ^ opb[63]) &&
					(post_op_q != OP_MUL || (ma != 64'd0 && mb != 64'd0));
				mul_a_q   <= ma;
				mul_b_q   <= mb;
				div_num_q <= {48'd0, ma, 16'd0};
				div_den_q <= mb;
				case (post_op_q)
					OP_ADD: calc_q <= sat_add(calc_q, opb);
					OP_SUB: calc_q <= sat_add(calc_q, 64'd0 - opb);
					OP_DIV: begin
						if (mb == 64'd0) begin
							calc_q <= calc_q[63] ? S64_MIN :
								((calc_q != 64'd0) ? S64_MAX : 64'd0);
						end
					end
					default: ;
				endcase
			end
			ST_POST_MUL: begin
				if (mul_rsp.done) begin
					calc_q <= from_mag(pneg_q, mul_rsp.prod[79:16],
						mul_rsp.prod[127:80] != 48'd0);
				end
			end
			ST_POST_DIV: begin
				if (div_rsp.done) begin
					calc_q <= from_mag(pneg_q, div_rsp.quot, div_rsp.over);
				end
			end
			ST_ST_INIT: begin
				idx_q <= oldest;
				k_q   <= '0;
				n_q   <= '0;
				sum_q <= 128'd0;
				mx_q  <= S64_MIN;
				mn_q  <= S64_MAX;
			end
			ST_ST_RD: begin
				avg_neg_q <= sum_q[127];
				div_num_q <= sum_q[127] ? (128'd0 - sum_q) : sum_q;
				div_den_q <= 64'(n_q);
			end
			ST_ST_ACC: begin
				idx_q <= next_idx(idx_q);
				k_q   <= k_q + CW'(1);
				if (rd.valid) begin
					sum_q <= sum_q + {{64{rd.calc[63]}}, rd.calc};
					n_q   <= n_q + CW'(1);
					if ($signed(rd.calc) > $signed(mx_q)) begin
						mx_q <= rd.calc;
					end
					if ($signed(rd.calc) < $signed(mn_q)) begin
						mn_q <= rd.calc;
					end
				end
			end
			default: ;
		endcase
	end

	// result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_load) begin
			out_last_q <= held_last_q;
			out_avg_q  <= held_avg_q;
			out_max_q  <= held_max_q;
			out_min_q  <= held_min_q;
			out_isv_q  <= held_valid_q;
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign last_value    = out_last_q;
	assign average_value = out_avg_q;
	assign max_value     = out_max_q;
	assign min_value     = out_min_q;
	assign is_valid      = out_isv_q;

endmodule

>>> src/wcs_ram.sv
// ----------------------------------------------------------------------------
// Windowed counter statistics - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/wcs_mul.sv
// ----------------------------------------------------------------------------
// Windowed counter statistics - iterative multiplier
// 64 x 64 unsigned product from four 32 x 32 partials, one per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wcs_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  wcs_pkg::mul_req_t req,
	output wcs_pkg::mul_rsp_t rsp
);
	import wcs_pkg::*;

	logic [63:0]  a_q, b_q;
	logic [2:0]   step_q;
	logic         busy_q, done_q;
	logic [63:0]  prod_s1;
	logic [1:0]   sh_s1;
	logic         pv_s1;
	logic [127:0] acc_q;
	logic [127:0] part;

	always_comb begin
		case (sh_s1)
			2'd0:    part = {64'd0, prod_s1};
			2'd1:    part = {32'd0, prod_s1, 32'd0};
			2'd2:    part = {prod_s1, 64'd0};
			default: part = 128'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pv_s1  <= 1'b0;
			step_q <= 3'd0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= 3'd0;
			done_q <= 1'b0;
			pv_s1  <= 1'b0;
		end else if (busy_q) begin
			pv_s1  <= (step_q < 3'd4);
			step_q <= step_q + 3'd1;
			busy_q <= (step_q != 3'd4);
			done_q <= (step_q == 3'd4);
		end else begin
			done_q <= 1'b0;
			pv_s1  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= 128'd0;
		end else begin
			prod_s1 <= (step_q[0] ? a_q[63:32] : a_q[31:0]) *
				(step_q[1] ? b_q[63:32] : b_q[31:0]);
			sh_s1   <= 2'(step_q[0]) + 2'(step_q[1]);
			if (pv_s1) begin
				acc_q <= acc_q + part;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

>>> src/wcs_div.sv
// ----------------------------------------------------------------------------
// Windowed counter statistics - iterative divider
// 128 / 64 restoring division, one quotient bit per cycle, overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wcs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  wcs_pkg::div_req_t req,
	output wcs_pkg::div_rsp_t rsp
);
	import wcs_pkg::*;

	logic [127:0] num_q;
	logic [63:0]  d_q, rem_q, quot_q;
	logic [6:0]   cnt_q;
	logic         busy_q, done_q, over_q;
	logic [63:0]  trial;
	logic         take;

	assign trial = {rem_q[62:0], num_q[127]};
	assign take  = (trial >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd127;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 7'd1;
			busy_q <= (cnt_q != 7'd0);
			done_q <= (cnt_q == 7'd0);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.dividend;
			d_q    <= req.divisor;
			rem_q  <= 64'd0;
			quot_q <= 64'd0;
			over_q <= 1'b0;
		end else if (busy_q) begin
			num_q  <= {num_q[126:0], 1'b0};
			rem_q  <= take ? (trial - d_q) : trial;
			quot_q <= {quot_q[62:0], take};
			over_q <= over_q | (take & cnt_q[6]);
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.over = over_q;

endmodule

>>> src/wcs_checker.sv
// ----------------------------------------------------------------------------
// Windowed counter statistics - port checker
// Watches the top-level handshakes over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "windowed_counter_statistics_unit_assert.svh"

module wcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] last_value
);

	// busy for at least the cycle after a beat is taken
	`WCS_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

	// a result only appears when the sequencer was busy
	`WCS_ASSERT_NOW(a_rise_while_busy, $rose(out_valid), !$past(in_ready))

	// held result keeps valid and value
	`WCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`WCS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(last_value))

endmodule

bind windowed_counter_statistics_unit wcs_checker u_wcs_checker (.*);
